/* design/plt_pkg.sv */
// positional list table package: field types, action and status codes, sizes
// depends on nothing; used by the interfaces, the list engine and the top level
`timescale 1ns / 1ps

package plt_pkg;

    localparam int CAPACITY = 64;
    localparam int ENTRY_W  = 32;
    localparam int ACTION_W = 3;
    localparam int POS_W    = 8;
    localparam int STATUS_W = 2;
    localparam int ADDR_W   = $clog2(CAPACITY);
    localparam int COUNT_W  = $clog2(CAPACITY + 1);
    localparam int CMP_W    = ((POS_W > COUNT_W) ? POS_W : COUNT_W) + 1;

    typedef logic [ENTRY_W-1:0] t_entry;
    typedef logic [ADDR_W-1:0]  t_addr;
    typedef logic [COUNT_W-1:0] t_count;
    typedef logic [POS_W-1:0]   t_pos;

    typedef enum logic [ACTION_W-1:0] {
        ACT_APPEND = 3'd0,
        ACT_INSERT = 3'd1,
        ACT_DELETE = 3'd2,
        ACT_GET    = 3'd3,
        ACT_LOCATE = 3'd4
    } t_action;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 2'd0,
        ST_BADPOS   = 2'd1,
        ST_FULL     = 2'd2,
        ST_NOTFOUND = 2'd3
    } t_status;

    typedef struct packed {
        logic [ACTION_W-1:0] action;
        t_pos                position;
        t_entry              entry_value;
    } t_req;

    typedef struct packed {
        t_status status;
        t_entry  entry_out;
        t_count  found_position;
        t_count  count;
    } t_rsp;

    // top level to engine
    typedef struct packed {
        logic start;
        logic take;
    } t_eng_ctl;

    // engine to top level
    typedef struct packed {
        logic idle;
        logic done;
    } t_eng_stat;

endpackage

/* design/plt_if.sv */
// request and response channel interfaces of the positional list table
// depends on plt_pkg
`timescale 1ns / 1ps

interface plt_req_if;
    logic                         valid;
    logic                         ready;
    logic [plt_pkg::ACTION_W-1:0] action;
    plt_pkg::t_pos                position;
    plt_pkg::t_entry              entry_value;

    modport source (output valid, output action, output position, output entry_value,
                    input ready);
    modport sink   (input valid, input action, input position, input entry_value,
                    output ready);
endinterface

interface plt_rsp_if;
    logic                         valid;
    logic                         ready;
    logic [plt_pkg::STATUS_W-1:0] status;
    plt_pkg::t_entry              entry_out;
    plt_pkg::t_count              found_position;
    plt_pkg::t_count              count;

    modport source (output valid, output status, output entry_out, output found_position,
                    output count, input ready);
    modport sink   (input valid, input status, input entry_out, input found_position,
                    input count, output ready);
endinterface

/* design/plt_engine.sv */
// list engine: entry memory, count and the sequencer that sweeps the memory
// depends on plt_pkg
`timescale 1ns / 1ps

module plt_engine (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  plt_pkg::t_eng_ctl  i_ctl,
    input  plt_pkg::t_req      i_req,
    output plt_pkg::t_eng_stat o_stat,
    output plt_pkg::t_rsp      o_rsp
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DONE
    } t_state;

    t_state           r_state;
    plt_pkg::t_action r_op;
    plt_pkg::t_entry  r_val;
    plt_pkg::t_addr   r_pos_idx;
    plt_pkg::t_count  r_cnt;
    plt_pkg::t_addr   r_idx;
    plt_pkg::t_addr   r_end;
    plt_pkg::t_addr   r_last;
    logic             r_down;
    logic             r_more;
    logic             r_rvld;
    logic             r_hit;
    plt_pkg::t_status r_status;
    plt_pkg::t_entry  r_got;
    plt_pkg::t_count  r_found;

    plt_pkg::t_entry  r_mem [plt_pkg::CAPACITY];
    plt_pkg::t_entry  r_rdata;

    logic             mem_we;
    plt_pkg::t_addr   mem_waddr;
    plt_pkg::t_entry  mem_wdata;
    logic             mem_re;

    plt_pkg::t_action          req_op;
    logic [plt_pkg::CMP_W-1:0] pos_c;
    logic [plt_pkg::CMP_W-1:0] cnt_c;
    logic [plt_pkg::CMP_W-1:0] pos_m1;
    plt_pkg::t_count           cnt_m1;
    plt_pkg::t_addr            pos_idx;
    plt_pkg::t_addr            cnt_addr;
    logic                      bad_ins;
    logic                      bad_acc;
    logic                      full;
    logic                      ins_at_end;
    logic                      scan_end;

    always_comb begin
        req_op     = plt_pkg::t_action'(i_req.action);
        pos_c      = plt_pkg::CMP_W'(i_req.position);
        cnt_c      = plt_pkg::CMP_W'(r_cnt);
        pos_m1     = pos_c - plt_pkg::CMP_W'(1);
        cnt_m1     = r_cnt - plt_pkg::COUNT_W'(1);
        pos_idx    = pos_m1[plt_pkg::ADDR_W-1:0];
        cnt_addr   = r_cnt[plt_pkg::ADDR_W-1:0];
        bad_ins    = (i_req.position == '0) || (pos_c > cnt_c + plt_pkg::CMP_W'(1));
        bad_acc    = (i_req.position == '0) || (pos_c > cnt_c);
        full       = (r_cnt == plt_pkg::COUNT_W'(plt_pkg::CAPACITY));
        ins_at_end = (pos_m1 == cnt_c);
        scan_end   = !r_more && !r_rvld;
    end

    // memory port control
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = r_last;
        mem_wdata = r_rdata;
        mem_re    = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_ctl.start && !full) begin
                    if (req_op == plt_pkg::ACT_APPEND
                        || (req_op == plt_pkg::ACT_INSERT && !bad_ins && ins_at_end)) begin
                        mem_we    = 1'b1;
                        mem_waddr = cnt_addr;
                        mem_wdata = i_req.entry_value;
                    end
                end
            end
            S_SCAN: begin
                mem_re = r_more;
                if (r_rvld && r_op == plt_pkg::ACT_INSERT) begin
                    mem_we    = 1'b1;
                    mem_waddr = r_last + plt_pkg::ADDR_W'(1);
                end else if (r_rvld && r_op == plt_pkg::ACT_DELETE && r_last != r_pos_idx) begin
                    mem_we    = 1'b1;
                    mem_waddr = r_last - plt_pkg::ADDR_W'(1);
                end else if (scan_end && r_op == plt_pkg::ACT_INSERT) begin
                    mem_we    = 1'b1;
                    mem_waddr = r_pos_idx;
                    mem_wdata = r_val;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            r_rdata <= r_mem[r_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_more  <= 1'b0;
            r_rvld  <= 1'b0;
            r_hit   <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    r_rvld <= 1'b0;
                    if (i_ctl.start) begin
                        r_op      <= req_op;
                        r_val     <= i_req.entry_value;
                        r_pos_idx <= pos_idx;
                        r_status  <= plt_pkg::ST_OK;
                        r_got     <= '0;
                        r_found   <= '0;
                        r_hit     <= 1'b0;
                        r_state   <= S_DONE;
                        unique case (req_op)
                            plt_pkg::ACT_APPEND: begin
                                if (full) begin
                                    r_status <= plt_pkg::ST_FULL;
                                end else begin
                                    r_cnt <= r_cnt + plt_pkg::COUNT_W'(1);
                                end
                            end
                            plt_pkg::ACT_INSERT: begin
                                if (bad_ins) begin
                                    r_status <= plt_pkg::ST_BADPOS;
                                end else if (full) begin
                                    r_status <= plt_pkg::ST_FULL;
                                end else if (ins_at_end) begin
                                    r_cnt <= r_cnt + plt_pkg::COUNT_W'(1);
                                end else begin
                                    r_idx   <= cnt_m1[plt_pkg::ADDR_W-1:0];
                                    r_end   <= pos_idx;
                                    r_down  <= 1'b1;
                                    r_more  <= 1'b1;
                                    r_state <= S_SCAN;
                                end
                            end
                            plt_pkg::ACT_DELETE: begin
                                if (bad_acc) begin
                                    r_status <= plt_pkg::ST_BADPOS;
                                end else begin
                                    r_idx   <= pos_idx;
                                    r_end   <= cnt_m1[plt_pkg::ADDR_W-1:0];
                                    r_down  <= 1'b0;
                                    r_more  <= 1'b1;
                                    r_state <= S_SCAN;
                                end
                            end
                            plt_pkg::ACT_GET: begin
                                if (bad_acc) begin
                                    r_status <= plt_pkg::ST_BADPOS;
                                end else begin
                                    r_idx   <= pos_idx;
                                    r_end   <= pos_idx;
                                    r_down  <= 1'b0;
                                    r_more  <= 1'b1;
                                    r_state <= S_SCAN;
                                end
                            end
                            plt_pkg::ACT_LOCATE: begin
                                r_status <= plt_pkg::ST_NOTFOUND;
                                if (r_cnt != '0) begin
                                    r_idx   <= '0;
                                    r_end   <= cnt_m1[plt_pkg::ADDR_W-1:0];
                                    r_down  <= 1'b0;
                                    r_more  <= 1'b1;
                                    r_state <= S_SCAN;
                                end
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                S_SCAN: begin
                    // issue the next read
                    if (r_more) begin
                        r_last <= r_idx;
                        r_rvld <= 1'b1;
                        if (r_idx == r_end) begin
                            r_more <= 1'b0;
                        end else if (r_down) begin
                            r_idx <= r_idx - plt_pkg::ADDR_W'(1);
                        end else begin
                            r_idx <= r_idx + plt_pkg::ADDR_W'(1);
                        end
                    end else begin
                        r_rvld <= 1'b0;
                    end
                    // consume the word read last cycle
                    if (r_rvld) begin
                        if ((r_op == plt_pkg::ACT_DELETE || r_op == plt_pkg::ACT_GET)
                            && r_last == r_pos_idx) begin
                            r_got <= r_rdata;
                        end
                        if (r_op == plt_pkg::ACT_LOCATE && !r_hit && r_rdata == r_val) begin
                            r_hit    <= 1'b1;
                            r_found  <= plt_pkg::COUNT_W'(r_last) + plt_pkg::COUNT_W'(1);
                            r_status <= plt_pkg::ST_OK;
                            r_more   <= 1'b0;
                        end
                    end
                    if (scan_end) begin
                        if (r_op == plt_pkg::ACT_INSERT) begin
                            r_cnt <= r_cnt + plt_pkg::COUNT_W'(1);
                        end else if (r_op == plt_pkg::ACT_DELETE) begin
                            r_cnt <= cnt_m1;
                        end
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (i_ctl.take) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_stat.idle         = (r_state == S_IDLE);
    assign o_stat.done         = (r_state == S_DONE);
    assign o_rsp.status        = r_status;
    assign o_rsp.entry_out     = r_got;
    assign o_rsp.found_position = r_found;
    assign o_rsp.count         = r_cnt;

endmodule

/* design/positional_list_table.sv */
// positional list table top level: channel handshakes and the response register
// depends on plt_pkg, plt_req_if, plt_rsp_if and plt_engine
//
//  channel | dir | transaction                               | fields
//  i_req   | in  | one action on the list                    | action, position, entry_value
//  o_rsp   | out | one result per request transaction        | status, entry_out,
//          |     |                                           | found_position, count
//
// one request at a time; the next is taken once the result has left the engine
// append, insert at the end, unused codes and rejected requests finish with no sweep;
// get reads one word, locate sweeps up to the first match or the last entry, and other
// inserts and deletes shift the entries from the position on (one memory word a cycle)
// the result register holds one result, so a stalled o_rsp delays only the following one
// synchronous reset empties the list; memory contents are not cleared
`timescale 1ns / 1ps

module positional_list_table (
    input  logic     i_clk,
    input  logic     i_rst_n,
    plt_req_if.sink  i_req,
    plt_rsp_if.source o_rsp
);

    plt_pkg::t_eng_ctl  eng_ctl;
    plt_pkg::t_eng_stat eng_stat;
    plt_pkg::t_req      eng_req;
    plt_pkg::t_rsp      eng_rsp;

    logic          r_out_valid;
    plt_pkg::t_rsp r_out;

    assign eng_req.action      = i_req.action;
    assign eng_req.position    = i_req.position;
    assign eng_req.entry_value = i_req.entry_value;

    assign i_req.ready   = eng_stat.idle;
    assign eng_ctl.start = i_req.valid && eng_stat.idle;
    assign eng_ctl.take  = eng_stat.done && (!r_out_valid || o_rsp.ready);

    plt_engine u_engine (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (eng_ctl),
        .i_req   (eng_req),
        .o_stat  (eng_stat),
        .o_rsp   (eng_rsp)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (eng_ctl.take) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (eng_ctl.take) begin
            r_out <= eng_rsp;
        end
    end

    assign o_rsp.valid          = r_out_valid;
    assign o_rsp.status         = r_out.status;
    assign o_rsp.entry_out      = r_out.entry_out;
    assign o_rsp.found_position = r_out.found_position;
    assign o_rsp.count          = r_out.count;

endmodule
